/* design/wdq_pkg.sv */
// package for the weight dequantizer: payload types, format codes, helper functions
`timescale 1ns / 1ps
package wdq_pkg;

	localparam int DEFAULT_BLOCK_ELEMENTS = 32;

	typedef enum logic [1:0] {
		FMT_F32  = 2'd0,
		FMT_F16  = 2'd1,
		FMT_BF16 = 2'd2,
		FMT_Q8   = 2'd3
	} fmt_t;

	typedef enum logic [0:0] {
		REG_FORMAT = 1'b0,
		REG_COUNT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] raw_word;
		logic        tensor_start;
	} in_word_t;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        last_element;
	} out_word_t;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	// half to single, exact; subnormals normalized with a priority search over 10 bits
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic       sgn;
		logic [4:0] ex;
		logic [9:0] man;
		logic [3:0] lz;
		logic [10:0] norm;
		logic [7:0] e8;
		sgn = h[15];
		ex = h[14:10];
		man = h[9:0];
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				lz = 4'(9 - i);
			end
		end
		norm = {1'b0, man} << (lz + 4'd1);
		e8 = 8'd0;
		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				half_to_single = {sgn, 31'd0};
			end else begin
				e8 = 8'd113 - 8'd1 - {4'd0, lz};
				half_to_single = {sgn, e8, norm[9:0], 13'd0};
			end
		end else if (ex == 5'h1F) begin
			half_to_single = {sgn, 8'hFF, (man != 10'd0), 22'd0};
		end else begin
			e8 = {3'd0, ex} + 8'd112;
			half_to_single = {sgn, e8, man, 13'd0};
		end
	endfunction

	// signed byte times a widened scale, inf and NaN included; the product fits in 32 bits exactly
	function automatic logic [31:0] scale_byte(input logic [31:0] s, input logic [7:0] b);
		logic        neg;
		logic [7:0]  mag;
		logic [23:0] sm;
		logic [31:0] prod;
		logic [4:0]  top;
		logic [31:0] sh;
		logic [8:0]  ex;
		logic        rsgn;
		neg = b[7];
		mag = neg ? 8'(-b) : b;
		rsgn = s[31] ^ neg;
		if (s[30:23] == 8'hFF) begin
			if (s[22:0] != 23'd0) begin
				scale_byte = {s[31], QNAN[30:0]};
			end else if (b == 8'd0) begin
				scale_byte = QNAN;
			end else begin
				scale_byte = {rsgn, 8'hFF, 23'd0};
			end
		end else begin
			// widened halves are always normal or zero
			sm = (s[30:23] == 8'd0) ? 24'd0 : {1'b1, s[22:0]};
			prod = 32'(sm) * 32'(mag);
			top = 5'd0;
			for (int i = 23; i < 32; i++) begin
				if (prod[i]) begin
					top = 5'(i);
				end
			end
			sh = prod >> (top - 5'd23);
			ex = {1'b0, s[30:23]} + 9'(top) - 9'd23;
			if (prod == 32'd0) begin
				scale_byte = {rsgn, 31'd0};
			end else begin
				scale_byte = {rsgn, ex[7:0], sh[22:0]};
			end
		end
	endfunction

endpackage

/* design/weight_dequantize_to_fp32_core.sv */
// Weight dequantizer: a raw 16-bit word stream is turned into IEEE single-precision words.
// Input channel in_valid/in_stall carries raw_word and tensor_start; output channel
// out_valid/out_stall carries value_bits and last_element. cfg_we/cfg_idx/cfg_data write
// source_format (index 0) and element_count (index 1); the user must write them only while the
// block is idle (not enforced). Each accepted word is decoded in one pass into a result
// register; an int8 data word yields up to two results, the others zero or one. A word
// accepted with two results stalls the input while the second result waits, so int8 data
// words are not taken back to back; every other format runs at one word a cycle while the
// receiver does not stall; the single result port is the limit. The input accepts while the
// second result slot is empty and the output register is empty or being drained, so a result
// leaving in the same cycle does not block the next word. When the receiver stalls, the
// result and any queued second result hold and the input stalls while a result waits in the
// output register. Reset clears formats, counters and valid flags.
`timescale 1ns / 1ps
module weight_dequantize_to_fp32_core #(
	parameter int BLOCK_ELEMENTS = wdq_pkg::DEFAULT_BLOCK_ELEMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wdq_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output wdq_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);

	localparam int WPB = 1 + (BLOCK_ELEMENTS + 1) / 2;
	localparam int PW = $clog2(WPB);

	logic [1:0]  fmt_q;
	logic [31:0] count_q;
	logic [PW-1:0] pos_q;
	logic [15:0] scale_q;
	logic [31:0] done_q;
	logic [15:0] low_q;
	logic        phase_q;

	wdq_pkg::out_word_t r0_q, r1_q;
	logic v0_q, v1_q;

	logic accept, pop;
	assign pop = v0_q && !out_stall;
	// room when the second slot is empty and the first is free or draining
	assign in_stall = v1_q || (v0_q && out_stall);
	assign accept = in_valid && !in_stall;

	logic [PW-1:0] pos_c;
	logic [31:0] done_c, sc;
	logic phase_c;
	logic [31:0] e0, e1;
	logic n0, n1;
	logic second_ok;
	logic [31:0] lim0, lim1;

	always_comb begin
		pos_c = in_data.tensor_start ? '0 : pos_q;
		done_c = in_data.tensor_start ? 32'd0 : done_q;
		phase_c = in_data.tensor_start ? 1'b0 : phase_q;
		sc = wdq_pkg::half_to_single(scale_q);
		second_ok = (32'(pos_c) * 2 - 32'd1) < 32'(BLOCK_ELEMENTS);
		e0 = 32'd0;
		e1 = 32'd0;
		n0 = 1'b0;
		n1 = 1'b0;
		case (wdq_pkg::fmt_t'(fmt_q))
			wdq_pkg::FMT_F32: begin
				e0 = {in_data.raw_word, low_q};
				n0 = phase_c;
			end
			wdq_pkg::FMT_F16: begin
				e0 = wdq_pkg::half_to_single(in_data.raw_word);
				n0 = 1'b1;
			end
			wdq_pkg::FMT_BF16: begin
				e0 = {in_data.raw_word, 16'd0};
				n0 = 1'b1;
			end
			default: begin
				e0 = wdq_pkg::scale_byte(sc, in_data.raw_word[7:0]);
				e1 = wdq_pkg::scale_byte(sc, in_data.raw_word[15:8]);
				n0 = (pos_c != '0);
				n1 = (pos_c != '0) && second_ok;
			end
		endcase
		lim0 = count_q - done_c;
		lim1 = lim0;
	end

	logic emit0, emit1;
	assign emit0 = n0 && (done_c < count_q);
	assign emit1 = n1 && ((done_c + 32'(emit0)) < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 2'd0;
			count_q <= 32'd0;
			pos_q <= '0;
			scale_q <= 16'd0;
			done_q <= 32'd0;
			low_q <= 16'd0;
			phase_q <= 1'b0;
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (wdq_pkg::reg_idx_t'(cfg_idx))
					wdq_pkg::REG_FORMAT: fmt_q <= cfg_data[1:0];
					wdq_pkg::REG_COUNT: count_q <= cfg_data;
					default: ;
				endcase
			end
			if (pop) begin
				v0_q <= v1_q;
				r0_q <= r1_q;
				v1_q <= 1'b0;
			end
			if (accept) begin
				done_q <= done_c + 32'(emit0) + 32'(emit1);
				pos_q <= pos_c;
				phase_q <= phase_c;
				case (wdq_pkg::fmt_t'(fmt_q))
					wdq_pkg::FMT_F32: begin
						phase_q <= !phase_c;
						if (!phase_c) low_q <= in_data.raw_word;
					end
					wdq_pkg::FMT_Q8: begin
						if (pos_c == '0) scale_q <= in_data.raw_word;
						pos_q <= (32'(pos_c) + 32'd1 >= 32'(WPB)) ? '0 : PW'(pos_c + 1'b1);
					end
					default: ;
				endcase
				// slot 0 is free here (empty or draining) since in_stall is low
				if (emit0) begin
					r0_q <= '{value_bits: e0, last_element: (lim0 == 32'd1)};
					v0_q <= 1'b1;
					if (emit1) begin
						r1_q <= '{value_bits: e1, last_element: (lim1 == 32'd2)};
						v1_q <= 1'b1;
					end
				end else if (emit1) begin
					r0_q <= '{value_bits: e1, last_element: (lim1 == 32'd1)};
					v0_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = v0_q;
	assign out_data = r0_q;

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q) else $error("second result slot filled without first");
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q <= count_q || $past(done_q > count_q)))
		else $error("element counter passed count");
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> !accept) else $error("word accepted with both slots full");

endmodule
